[sv/gwwb_pkg.sv]
`default_nettype none

package gwwb_pkg;

  localparam int MAX_TEXT_LEN     = 65536;
  localparam int GLYPH_WIDTH_BITS = 8;
  localparam int POS_W            = $clog2(MAX_TEXT_LEN + 1);
  localparam int TABLE_DEPTH      = 256;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_TEXT = 2'd1;
  localparam logic [1:0] OP_END  = 2'd2;

  localparam logic [1:0] BRK_WRAP    = 2'd0;
  localparam logic [1:0] BRK_NEWLINE = 2'd1;
  localparam logic [1:0] BRK_FINAL   = 2'd2;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] char_code;
    logic [7:0] char_width;
  } item_t;

  typedef struct packed {
    logic [1:0]  break_kind;
    logic [15:0] next_line_start;
    logic [15:0] finished_width;
    logic        last_of_run;
  } result_t;

  // 17-bit sum clamped to 16 bits
  function automatic logic [15:0] sat16(input logic [16:0] s);
    sat16 = s[16] ? 16'hFFFF : s[15:0];
  endfunction

endpackage

`default_nettype wire

[sv/greedy_word_wrap_breaker.sv]
`default_nettype none

// Greedy word-wrap line breaker. Load glyph widths with operation 0, then stream
// text bytes (operation 1) and close each text with operation 2. A space ends a
// word; at each word end the line breaks before the word when it would overflow
// wrap_limit (zero turns wrapping off). Newline and end of text give hard breaks,
// preceded by a wrap break when one is due, so one input can yield two results.
// One input item is taken per clock while the output queue can hold two more
// results; otherwise the input stalls. The width table read at the input edge
// feeds a single add-compare stage via the stage-1 registers, and up to two
// results per item go into a four-entry output queue. A width load is visible to
// a text byte in the very next cycle. No clearing pass after reset; widths must
// be loaded before use. The user must write wrap_limit only while the block is idle.
module greedy_word_wrap_breaker (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wrap_limit_we,
  input  wire logic [15:0]     wrap_limit_wdata,
  input  wire logic            item_valid,
  output logic                 item_stall,
  input  wire gwwb_pkg::item_t item,
  output logic                 result_valid,
  input  wire logic            result_stall,
  output gwwb_pkg::result_t    result
);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  logic [15:0] wrap_limit;

  // stage 1
  logic        s1_valid;
  logic [1:0]  s1_op;
  logic [7:0]  s1_code;
  logic [gwwb_pkg::GLYPH_WIDTH_BITS-1:0] glyph_width;

  // line state
  logic [15:0]               line_width, line_width_next;
  logic [15:0]               word_width, word_width_next;
  logic [15:0]               word_start, word_start_next;
  logic [gwwb_pkg::POS_W-1:0] byte_position, byte_position_next;

  // output queue
  gwwb_pkg::result_t queue [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  logic accept, room, s1_go, pop;
  logic [1:0] n_push;
  gwwb_pkg::result_t r0, r1, wrap_r, hard_r;

  logic [15:0]               ww_eff, ww_add, lw_closed, pos1;
  logic [16:0]               sum;
  logic                      wrap, text_ok;
  logic [gwwb_pkg::POS_W-1:0] bp_inc;

  assign room       = count <= QCNT_W'(QDEPTH - 2);
  assign s1_go      = s1_valid && room;
  assign item_stall = s1_valid && !room;
  assign accept     = item_valid && !item_stall;

  assign result_valid = count != '0;
  assign result       = queue[rd_ptr];
  assign pop          = result_valid && !result_stall;

  gwwb_ram #(
    .WIDTH(gwwb_pkg::GLYPH_WIDTH_BITS),
    .DEPTH(gwwb_pkg::TABLE_DEPTH)
  ) u_width_table (
    .clk  (clk),
    .we   (accept && item.operation == gwwb_pkg::OP_LOAD),
    .waddr(item.char_code),
    .wdata(item.char_width[gwwb_pkg::GLYPH_WIDTH_BITS-1:0]),
    .re   (accept),
    .raddr(item.char_code),
    .rdata(glyph_width)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_limit <= '0;
    end else if (wrap_limit_we) begin
      wrap_limit <= wrap_limit_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op   <= item.operation;
      s1_code <= item.char_code;
    end
  end

  // word close: add-compare against the limit
  assign bp_inc  = byte_position + 1'b1;
  assign pos1    = bp_inc[15:0];
  assign text_ok = byte_position < gwwb_pkg::POS_W'(gwwb_pkg::MAX_TEXT_LEN);
  assign ww_add  = gwwb_pkg::sat16({1'b0, word_width} +
                                   17'(glyph_width));
  assign ww_eff  = (s1_op == gwwb_pkg::OP_TEXT && s1_code != gwwb_pkg::CH_NEWLINE)
                   ? ww_add : word_width;
  assign sum       = {1'b0, line_width} + {1'b0, ww_eff};
  assign wrap      = (wrap_limit != '0) && (line_width != '0) &&
                     (sum > {1'b0, wrap_limit});
  assign lw_closed = wrap ? ww_eff : gwwb_pkg::sat16(sum);

  always_comb begin
    line_width_next    = line_width;
    word_width_next    = word_width;
    word_start_next    = word_start;
    byte_position_next = byte_position;
    n_push             = 2'd0;
    wrap_r             = '{break_kind: gwwb_pkg::BRK_WRAP, next_line_start: word_start,
                           finished_width: line_width, last_of_run: 1'b0};
    hard_r             = '{break_kind: gwwb_pkg::BRK_NEWLINE, next_line_start: pos1,
                           finished_width: lw_closed, last_of_run: 1'b1};
    r0                 = wrap_r;
    r1                 = hard_r;
    if (s1_go) begin
      unique case (s1_op)
        gwwb_pkg::OP_TEXT: begin
          if (text_ok) begin
            byte_position_next = bp_inc;
            if (s1_code == gwwb_pkg::CH_NEWLINE) begin
              line_width_next = '0;
              word_width_next = '0;
              word_start_next = pos1;
              n_push          = wrap ? 2'd2 : 2'd1;
              if (!wrap) begin
                r0 = hard_r;
              end
            end else if (s1_code == gwwb_pkg::CH_SPACE) begin
              line_width_next   = lw_closed;
              word_width_next   = '0;
              word_start_next   = pos1;
              n_push            = {1'b0, wrap};
              r0.last_of_run    = 1'b1;
            end else begin
              word_width_next = ww_add;
            end
          end
        end
        gwwb_pkg::OP_END: begin
          hard_r.break_kind      = gwwb_pkg::BRK_FINAL;
          hard_r.next_line_start = '0;
          r1                     = hard_r;
          line_width_next        = '0;
          word_width_next        = '0;
          word_start_next        = '0;
          byte_position_next     = '0;
          n_push                 = wrap ? 2'd2 : 2'd1;
          if (!wrap) begin
            r0 = hard_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width    <= '0;
      word_width    <= '0;
      word_start    <= '0;
      byte_position <= '0;
    end else begin
      line_width    <= line_width_next;
      word_width    <= word_width_next;
      word_start    <= word_start_next;
      byte_position <= byte_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      queue[wr_ptr] <= r0;
    end
    if (n_push == 2'd2) begin
      queue[wr_ptr + 1'b1] <= r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(n_push);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      count  <= count + QCNT_W'(n_push) - QCNT_W'(pop);
    end
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("output queue overflow");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> s1_valid && count > QCNT_W'(QDEPTH - 2))
    else $error("input stalled without a waiting item");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_op == gwwb_pkg::OP_END |=>
      line_width == '0 && word_width == '0 && byte_position == '0)
    else $error("line state not cleared after end of text");

  a_final_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.break_kind == gwwb_pkg::BRK_FINAL |->
      result.last_of_run && result.next_line_start == '0)
    else $error("final line result malformed");

  a_wrap_nonempty: assert property (@(posedge clk) disable iff (rst)
    s1_go && wrap |-> wrap_limit != '0 && line_width != '0)
    else $error("wrap break on empty line or with wrapping off");

endmodule

`default_nettype wire

[sv/gwwb_ram.sv]
`default_nettype none

module gwwb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
